### rtl/core/trp_pkg.sv
// Package for the track record processor: controller states, command bundle,
// fixed-point constants, the CORDIC arctangent table and the output saturation.
// Depends on nothing; the controller, the datapath and the top level import it.
package trp_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_INIT,
    ST_ITER,
    ST_FINISH
  } trp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input transaction
    logic prep;    // heading reduction and the first products
    logic init;    // quadrant split, CORDIC start vector, hour estimate
    logic iter;    // one CORDIC micro-rotation, plus one time-split step in the early iterations
    logic finish;  // round, rotate by quadrant, saturate, load result register
  } trp_cmd_t;

  // Arctangent table depth and its index width.
  localparam int TABLE_LEN = 24;
  localparam int TAB_IDX_W = 5;

  // Steps of the time split, run beside the CORDIC iterations.
  localparam int TS_HOUR_FIX  = 0;
  localparam int TS_MIN_MUL   = 1;
  localparam int TS_MIN_SPLIT = 2;
  localparam int TS_MIN_FIX   = 3;
  localparam int TS_SECONDS   = 4;
  localparam int TS_TRACK     = 5;

  // CORDIC gain 0.60725293500888 in Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [53:0] GAIN_RND = 54'd2097152;

  // Reciprocals for the decimal split, both underestimates so that one
  // compare and subtract corrects the quotient.
  localparam logic [10:0] HOUR_RECIP = 11'd1677;   // floor(2^24 / 10000)
  localparam logic [9:0]  MIN_RECIP  = 10'd655;    // floor(2^16 / 100)

  localparam logic [17:0] TEN_THOUSAND = 18'd10000;
  localparam logic [13:0] ONE_HUNDRED  = 14'd100;
  localparam logic [17:0] SEC_PER_HOUR = 18'd3600;
  localparam logic [17:0] SEC_PER_MIN  = 18'd60;
  localparam logic [17:0] SEC_PER_DAY  = 18'd86400;

  // Heading angles in units of 1/128 degree.
  localparam logic [17:0] TWO_TURNS   = 18'd92160;
  localparam logic [17:0] THREE_TURNS = 18'd138240;
  localparam logic [17:0] ONE_TURN    = 18'd46080;
  localparam logic [15:0] QUARTER_1   = 16'd11520;
  localparam logic [15:0] QUARTER_2   = 16'd23040;
  localparam logic [15:0] QUARTER_3   = 16'd34560;

  // atan(2^-i) in degrees, scaled by 2^23 and rounded.
  function automatic logic signed [31:0] atan_deg23(input logic [TAB_IDX_W-1:0] idx);
    logic signed [31:0] val;
    unique case (idx)
      5'd0:    val = 32'sd377487360;
      5'd1:    val = 32'sd222843801;
      5'd2:    val = 32'sd117744544;
      5'd3:    val = 32'sd59768969;
      5'd4:    val = 32'sd30000467;
      5'd5:    val = 32'sd15014858;
      5'd6:    val = 32'sd7509261;
      5'd7:    val = 32'sd3754860;
      5'd8:    val = 32'sd1877459;
      5'd9:    val = 32'sd938733;
      5'd10:   val = 32'sd469367;
      5'd11:   val = 32'sd234683;
      5'd12:   val = 32'sd117342;
      5'd13:   val = 32'sd58671;
      5'd14:   val = 32'sd29335;
      5'd15:   val = 32'sd14668;
      5'd16:   val = 32'sd7334;
      5'd17:   val = 32'sd3667;
      5'd18:   val = 32'sd1833;
      5'd19:   val = 32'sd917;
      5'd20:   val = 32'sd458;
      5'd21:   val = 32'sd229;
      5'd22:   val = 32'sd115;
      5'd23:   val = 32'sd57;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

  // Clamp a rounded coordinate to the 25-bit signed output range.
  function automatic logic signed [24:0] sat_pos(input logic signed [27:0] v);
    logic signed [24:0] res;
    if (v > 28'sd16777215) begin
      res = 25'sd16777215;
    end else if (v < -28'sd16777216) begin
      res = -25'sd16777216;
    end else begin
      res = v[24:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/trp_if.sv
// Channel interfaces of the track record processor: the record input channel
// and the result channel, each with valid/ready flow control.
// Depends on nothing.
interface trp_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        track_id;
  logic [17:0]        day_clock;
  logic signed [16:0] heading_deg;
  logic [23:0]        distance;

  modport source (output valid, output track_id, output day_clock,
                  output heading_deg, output distance, input ready);
  modport sink   (input valid, input track_id, input day_clock,
                  input heading_deg, input distance, output ready);
endinterface

interface trp_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         hour_part;
  logic [5:0]         minute_part;
  logic [5:0]         second_part;
  logic signed [24:0] x_pos;
  logic signed [24:0] y_pos;
  logic [16:0]        elapsed_seconds;
  logic               same_track;
  logic               bad_time;

  modport source (output valid, output hour_part, output minute_part,
                  output second_part, output x_pos, output y_pos,
                  output elapsed_seconds, output same_track, output bad_time,
                  input ready);
  modport sink   (input valid, input hour_part, input minute_part,
                  input second_part, input x_pos, input y_pos,
                  input elapsed_seconds, input same_track, input bad_time,
                  output ready);
endinterface

### rtl/core/trp_ctrl.sv
// Controller of the track record processor: sequences one transaction through
// the datapath and owns the result valid flag. Depends on trp_pkg.
module trp_ctrl
  import trp_pkg::*;
#(
  parameter int  CORDIC_STAGES = 16,
  localparam int CNT_W         = $clog2(CORDIC_STAGES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output trp_cmd_t         cmd,
  output logic [CNT_W-1:0] iter_idx
);

  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_STAGES - 1);

  trp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register can be loaded once it is empty or being drained.
  assign res_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_INIT;
      ST_INIT:   state_nxt = ST_ITER;
      ST_ITER:   if (cnt_r == LAST_ITER) state_nxt = ST_FINISH;
      ST_FINISH: if (res_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_INIT) begin
      cnt_nxt = '0;
    end else if (state_r == ST_ITER) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.prep   = (state_r == ST_PREP);
    cmd.init   = (state_r == ST_INIT);
    cmd.iter   = (state_r == ST_ITER);
    cmd.finish = res_load;
  end

  assign out_valid = out_valid_r;
  assign iter_idx  = cnt_r;

endmodule

### rtl/core/trp_dp.sv
// Datapath of the track record processor: input registers, the iterative
// CORDIC unit, the decimal time split, the track memory and the result
// register. Driven by trp_ctrl; depends on trp_pkg.
module trp_dp
  import trp_pkg::*;
#(
  parameter int  CORDIC_STAGES = 16,
  parameter int  ID_BITS       = 16,
  localparam int CNT_W         = $clog2(CORDIC_STAGES),
  localparam int ID_W          = (ID_BITS < 16) ? ID_BITS : 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  trp_cmd_t           cmd,
  input  logic [CNT_W-1:0]   iter_idx,
  input  logic [15:0]        in_track_id,
  input  logic [17:0]        in_day_clock,
  input  logic signed [16:0] in_heading_deg,
  input  logic [23:0]        in_distance,
  output logic [4:0]         out_hour_part,
  output logic [5:0]         out_minute_part,
  output logic [5:0]         out_second_part,
  output logic signed [24:0] out_x_pos,
  output logic signed [24:0] out_y_pos,
  output logic [16:0]        out_elapsed_seconds,
  output logic               out_same_track,
  output logic               out_bad_time
);

  // Captured transaction.
  logic [ID_W-1:0]    id_r;
  logic [17:0]        t_r;
  logic signed [16:0] head_r;
  logic [23:0]        dist_r;

  // Heading and CORDIC.
  logic [15:0]        ang_r;
  logic [53:0]        xprod_r;
  logic [1:0]         quad_r, quad_nxt;
  logic signed [34:0] x_r, x_nxt;
  logic signed [34:0] y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;

  // Time split.
  logic [28:0]        tprod_r;
  logic [4:0]         hh_r;
  logic [14:0]        rem_r;
  logic [23:0]        mprod_r;
  logic [6:0]         mm_r;
  logic [7:0]         ss_r;
  logic [17:0]        now_r;
  logic               bad_r;
  logic               same_r;
  logic [16:0]        elapsed_r;

  // Track memory.
  logic [ID_W-1:0]    last_track_r;
  logic [16:0]        last_time_r;

  // Result register.
  logic [4:0]         res_hh_r;
  logic [5:0]         res_mm_r;
  logic [5:0]         res_ss_r;
  logic signed [24:0] res_x_r;
  logic signed [24:0] res_y_r;
  logic [16:0]        res_el_r;
  logic               res_same_r;
  logic               res_bad_r;

  logic signed [18:0] head_ext;
  logic [17:0]        head_sum;
  logic [17:0]        ang_red;
  logic [13:0]        ang_rem;
  logic [4:0]         hh_est;
  logic [17:0]        hh_mul;
  logic [6:0]         mm_est;
  logic [13:0]        mm_mul;
  logic signed [34:0] dx;
  logic signed [34:0] dy;
  logic signed [31:0] atan_i;
  logic signed [34:0] x_rnd;
  logic signed [34:0] y_rnd;
  logic signed [27:0] xr;
  logic signed [27:0] yr;
  logic signed [27:0] ox;
  logic signed [27:0] oy;
  logic [17:0]        elapsed_full;

  // Heading reduced modulo one turn: the biased value stays below four turns.
  always_comb begin
    head_ext = {{2{head_r[16]}}, head_r};
    head_sum = 18'(head_ext + $signed({1'b0, TWO_TURNS}));
    if (head_sum >= THREE_TURNS) begin
      ang_red = head_sum - THREE_TURNS;
    end else if (head_sum >= TWO_TURNS) begin
      ang_red = head_sum - TWO_TURNS;
    end else if (head_sum >= ONE_TURN) begin
      ang_red = head_sum - ONE_TURN;
    end else begin
      ang_red = head_sum;
    end
  end

  // Quadrant and remainder angle.
  always_comb begin
    if (ang_r >= QUARTER_3) begin
      quad_nxt = 2'd3;
      ang_rem  = 14'(ang_r - QUARTER_3);
    end else if (ang_r >= QUARTER_2) begin
      quad_nxt = 2'd2;
      ang_rem  = 14'(ang_r - QUARTER_2);
    end else if (ang_r >= QUARTER_1) begin
      quad_nxt = 2'd1;
      ang_rem  = 14'(ang_r - QUARTER_1);
    end else begin
      quad_nxt = 2'd0;
      ang_rem  = ang_r[13:0];
    end
  end

  // Hour and minute estimates from the registered reciprocal products.
  assign hh_est = tprod_r[28:24];
  assign hh_mul = 18'(hh_est) * TEN_THOUSAND;
  assign mm_est = mprod_r[22:16];
  assign mm_mul = 14'(mm_est) * ONE_HUNDRED;

  // One CORDIC micro-rotation through the two variable shifters that every iteration reuses.
  assign dx     = y_r >>> iter_idx;
  assign dy     = x_r >>> iter_idx;
  assign atan_i = atan_deg23(TAB_IDX_W'(iter_idx));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cmd.init) begin
      x_nxt = $signed({3'b000, xprod_r[53:22]});
      y_nxt = '0;
      z_nxt = $signed({2'b00, ang_rem, 16'h0000});
    end else if (cmd.iter) begin
      if (!z_r[31]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_i;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_i;
      end
    end
  end

  // Round half up, then rotate by the quadrant.
  always_comb begin
    x_rnd = x_r + 35'sd128;
    y_rnd = y_r + 35'sd128;
    xr    = {x_rnd[34], x_rnd[34:8]};
    yr    = {y_rnd[34], y_rnd[34:8]};
    case (quad_r)
      2'd1:    begin ox = -yr; oy = xr;  end
      2'd2:    begin ox = -xr; oy = -yr; end
      2'd3:    begin ox = yr;  oy = -xr; end
      default: begin ox = xr;  oy = yr;  end
    endcase
  end

  // Seconds since the previous record, wrapping over midnight.
  always_comb begin
    if (now_r >= 18'(last_time_r)) begin
      elapsed_full = now_r - 18'(last_time_r);
    end else begin
      elapsed_full = now_r + SEC_PER_DAY - 18'(last_time_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_track_id[ID_W-1:0];
      t_r    <= in_day_clock;
      head_r <= in_heading_deg;
      dist_r <= in_distance;
    end
    if (cmd.prep) begin
      ang_r   <= ang_red[15:0];
      xprod_r <= 54'(dist_r) * 54'(GAIN_Q30) + GAIN_RND;
      tprod_r <= 29'(t_r) * 29'(HOUR_RECIP);
    end
    if (cmd.init) begin
      quad_r <= quad_nxt;
      hh_r   <= hh_est;
      rem_r  <= 15'(t_r - hh_mul);
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (cmd.iter) begin
      if (iter_idx == CNT_W'(TS_HOUR_FIX)) begin
        if (rem_r >= 15'(TEN_THOUSAND)) begin
          hh_r  <= hh_r + 5'd1;
          rem_r <= rem_r - 15'(TEN_THOUSAND);
        end
      end
      if (iter_idx == CNT_W'(TS_MIN_MUL)) begin
        mprod_r <= 24'(rem_r[13:0]) * 24'(MIN_RECIP);
      end
      if (iter_idx == CNT_W'(TS_MIN_SPLIT)) begin
        mm_r <= mm_est;
        ss_r <= 8'(rem_r[13:0] - mm_mul);
      end
      if (iter_idx == CNT_W'(TS_MIN_FIX)) begin
        if (ss_r >= 8'(ONE_HUNDRED)) begin
          mm_r <= mm_r + 7'd1;
          ss_r <= ss_r - 8'(ONE_HUNDRED);
        end
      end
      if (iter_idx == CNT_W'(TS_SECONDS)) begin
        bad_r <= (hh_r > 5'd23) || (mm_r > 7'd59) || (ss_r > 8'd59);
        now_r <= 18'(hh_r) * SEC_PER_HOUR + 18'(mm_r) * SEC_PER_MIN + 18'(ss_r);
      end
      if (iter_idx == CNT_W'(TS_TRACK)) begin
        same_r    <= (id_r == last_track_r);
        elapsed_r <= (!bad_r && (id_r == last_track_r)) ? elapsed_full[16:0] : '0;
      end
    end
    if (cmd.finish) begin
      res_hh_r   <= bad_r ? '0 : hh_r;
      res_mm_r   <= bad_r ? '0 : mm_r[5:0];
      res_ss_r   <= bad_r ? '0 : ss_r[5:0];
      res_x_r    <= sat_pos(ox);
      res_y_r    <= sat_pos(oy);
      res_el_r   <= elapsed_r;
      res_same_r <= same_r;
      res_bad_r  <= bad_r;
    end
  end

  // Track memory: updated only by well-formed times.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_track_r <= '0;
      last_time_r  <= '0;
    end else if (cmd.iter && (iter_idx == CNT_W'(TS_TRACK)) && !bad_r) begin
      last_track_r <= id_r;
      last_time_r  <= now_r[16:0];
    end
  end

  assign out_hour_part       = res_hh_r;
  assign out_minute_part     = res_mm_r;
  assign out_second_part     = res_ss_r;
  assign out_x_pos           = res_x_r;
  assign out_y_pos           = res_y_r;
  assign out_elapsed_seconds = res_el_r;
  assign out_same_track      = res_same_r;
  assign out_bad_time        = res_bad_r;

endmodule

### rtl/core/track_record_processor_unit.sv
// Top level of the track record processor: joins the controller and the
// datapath to the record and result channels. Depends on trp_pkg, trp_if,
// trp_ctrl and trp_dp.
//
// Each input transaction is one tracking record (track id, decimal hhmmss
// time, heading in 1/128 degree, distance in 1/256) and yields exactly one
// result transaction: the hours, minutes and seconds of the time, the x and y
// position from a gain-compensated CORDIC rotation, the seconds elapsed since
// the previous record of the same track, a same-track flag and a malformed
// time flag. A record passes from acceptance through the PREP and
// INIT steps, the iterations of the single CORDIC rotation unit that
// the datapath steps through one micro-rotation per cycle, and the
// FINISH step that loads the result register; the decimal time split
// runs in the first six of those iterations. The block takes one
// record at a time and is ready again in the cycle after the result
// is loaded. The result sits in an output register, so a new record is
// accepted while the previous result waits to be taken; a result that
// is not taken holds the next one in the final step. The block keeps the
// last track id and the last record time, both zero after reset, so track id
// zero matches right after reset and measures time from midnight. A record
// whose time is malformed (hours above 23, minutes or seconds above 59)
// reports zero time fields and zero elapsed seconds, leaves the stored track
// untouched, and still reports the position and the same-track flag. Times
// earlier than the stored one wrap over midnight. Headings beyond a full turn
// are reduced modulo 360 degrees, and positions saturate to the 25-bit
// signed range. Only the low ID_BITS bits of the track id take part in the
// match. Reset is synchronous and active low.
module track_record_processor_unit
  import trp_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int ID_BITS       = 16
) (
  input  logic clk,
  input  logic rst_n,
  trp_in_if.sink    in_rec,
  trp_out_if.source out_res
);

  localparam int CNT_W = $clog2(CORDIC_STAGES);

  trp_cmd_t         cmd;
  logic [CNT_W-1:0] iter_idx;

  // Sequencing and result flow control.
  trp_ctrl #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_rec.valid),
    .in_ready  (in_rec.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .cmd       (cmd),
    .iter_idx  (iter_idx)
  );

  // Arithmetic, track memory and result register.
  trp_dp #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .iter_idx            (iter_idx),
    .in_track_id         (in_rec.track_id),
    .in_day_clock        (in_rec.day_clock),
    .in_heading_deg      (in_rec.heading_deg),
    .in_distance         (in_rec.distance),
    .out_hour_part       (out_res.hour_part),
    .out_minute_part     (out_res.minute_part),
    .out_second_part     (out_res.second_part),
    .out_x_pos           (out_res.x_pos),
    .out_y_pos           (out_res.y_pos),
    .out_elapsed_seconds (out_res.elapsed_seconds),
    .out_same_track      (out_res.same_track),
    .out_bad_time        (out_res.bad_time)
  );

endmodule

### tb/sv/track_record_checker.sv
// Result checker for the track record processor: predicts each result from the
// accepted record transactions and compares it with the result channel.
// Depends on the channel interfaces in trp_if.sv.
`timescale 1ns / 1ps

module track_record_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int ID_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  trp_in_if           rec_mon,
  trp_out_if          res_mon,
  output int unsigned mismatch_count,
  output int unsigned open_count
);

  typedef struct {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic [16:0]        elapsed;
    logic               same;
    logic               bad;
  } track_fix_t;

  localparam logic [15:0] ID_MASK = (ID_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << ID_BITS) - 1);
  localparam longint GAIN_Q30     = 652032874;
  localparam longint FULL_TURN    = 46080;
  localparam longint QUARTER_TURN = 11520;
  localparam longint POS_MAX      = 16777215;
  localparam longint POS_MIN      = -16777216;
  localparam int unsigned DAY_SECS = 86400;

  // Arctangent of 2^-i in degrees, scaled by 2^23.
  longint atan_step [24] = '{
    377487360, 222843801, 117744544, 59768969,
    30000467,  15014858,  7509261,   3754860,
    1877459,   938733,    469367,    234683,
    117342,    58671,     29335,     14668,
    7334,      3667,      1833,      917,
    458,       229,       115,       57
  };

  logic [15:0]  held_track;
  int unsigned  held_secs;
  int unsigned  result_index;
  track_fix_t   expected_fixes [$];

  initial begin
    mismatch_count = 0;
    open_count     = 0;
    result_index   = 0;
  end

  // Works out the result of one record and, for a well-formed time, advances the remembered track.
  function automatic track_fix_t predict_fix(input logic [15:0] id_raw,
                                             input logic [17:0] hhmmss,
                                             input logic signed [16:0] heading,
                                             input logic [23:0] radius);
    track_fix_t  f;
    logic [15:0] id;
    int unsigned hh, mm, ss, now;
    longint      angle, quad, part, x, y, z, dx, dy, xr, yr, ox, oy;

    id = id_raw & ID_MASK;
    hh = hhmmss / 10000;
    mm = (hhmmss % 10000) / 100;
    ss = hhmmss % 100;
    f.bad  = (hh > 23) || (mm > 59) || (ss > 59);
    f.same = (id == held_track);

    angle = (longint'(heading) + 2 * FULL_TURN) % FULL_TURN;
    quad  = angle / QUARTER_TURN;
    part  = angle % QUARTER_TURN;
    x = (longint'(radius) * GAIN_Q30 + 64'sd2097152) >>> 22;
    y = 0;
    z = part * 65536;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    xr = (x + 128) >>> 8;
    yr = (y + 128) >>> 8;
    case (quad)
      1: begin
        ox = -yr;
        oy = xr;
      end
      2: begin
        ox = -xr;
        oy = -yr;
      end
      3: begin
        ox = yr;
        oy = -xr;
      end
      default: begin
        ox = xr;
        oy = yr;
      end
    endcase
    ox = (ox > POS_MAX) ? POS_MAX : (ox < POS_MIN) ? POS_MIN : ox;
    oy = (oy > POS_MAX) ? POS_MAX : (oy < POS_MIN) ? POS_MIN : oy;
    f.x = 25'(ox);
    f.y = 25'(oy);

    f.elapsed = '0;
    if (!f.bad) begin
      now = hh * 3600 + mm * 60 + ss;
      if (f.same) begin
        f.elapsed = 17'((now >= held_secs) ? now - held_secs : now + DAY_SECS - held_secs);
      end
      held_track = id;
      held_secs  = now;
    end
    f.hour   = f.bad ? 5'd0 : 5'(hh);
    f.minute = f.bad ? 6'd0 : 6'(mm);
    f.second = f.bad ? 6'd0 : 6'(ss);
    return f;
  endfunction

  task automatic compare_field(input string field, input longint want_v,
                               input longint got_v);
    if (want_v != got_v) begin
      if (mismatch_count < 10) begin
        $display("result %0d: %s expected %0d, got %0d", result_index, field,
                 want_v, got_v);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    track_fix_t want;
    if (!rst_n) begin
      held_track = '0;
      held_secs  = 0;
      expected_fixes.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_fixes.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("result %0d arrived with nothing expected", result_index);
          end
          mismatch_count++;
        end else begin
          want = expected_fixes.pop_front();
          compare_field("hour_part", want.hour, res_mon.hour_part);
          compare_field("minute_part", want.minute, res_mon.minute_part);
          compare_field("second_part", want.second, res_mon.second_part);
          compare_field("x_pos", want.x, res_mon.x_pos);
          compare_field("y_pos", want.y, res_mon.y_pos);
          compare_field("elapsed_seconds", want.elapsed, res_mon.elapsed_seconds);
          compare_field("same_track", want.same, res_mon.same_track);
          compare_field("bad_time", want.bad, res_mon.bad_time);
        end
        result_index++;
      end
      if (rec_mon.valid && rec_mon.ready) begin
        expected_fixes.push_back(predict_fix(rec_mon.track_id, rec_mon.day_clock,
                                             rec_mon.heading_deg, rec_mon.distance));
      end
    end
    open_count = expected_fixes.size();
  end

endmodule

### tb/sv/track_record_processor_unit_tb.sv
// Testbench top for the track record processor: clock, reset, record stimulus,
// result flow control and the final verdict. Depends on trp_if.sv, the block
// itself and track_record_checker.sv.
`timescale 1ns / 1ps

module track_record_processor_unit_tb;

  localparam int STAGES = 16;
  localparam int ID_W   = 16;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned open_fixes;

  // When set, neither side idles at random.
  bit steady;
  // Raised by the stimulus to make the receiver start its long hold-off.
  bit hold_start;

  trp_in_if  rec_ch ();
  trp_out_if res_ch ();

  track_record_processor_unit #(
    .CORDIC_STAGES(STAGES),
    .ID_BITS      (ID_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rec (rec_ch),
    .out_res(res_ch)
  );

  // The checker watches both channels and keeps its own prediction of every
  // result; the top only reads its mismatch count and the number of results
  // still outstanding.
  track_record_checker #(
    .CORDIC_STAGES(STAGES),
    .ID_BITS      (ID_W)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_mon       (rec_ch),
    .res_mon       (res_ch),
    .mismatch_count(mismatches),
    .open_count    (open_fixes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: this limit lies many times over the slowest correct run.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one record transaction. The task is entered at a falling edge and
  // returns at the falling edge after the transaction was taken, leaving valid
  // high; the next call either lowers it for an idle cycle or puts the next
  // record on the channel, so valid gets a single update per time step.
  task automatic offer_record(input logic [15:0] id, input logic [17:0] hhmmss,
                              input logic signed [16:0] heading,
                              input logic [23:0] radius);
    while (!steady && $urandom_range(99) < 8) begin
      rec_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rec_ch.valid       <= 1'b1;
    rec_ch.track_id    <= id;
    rec_ch.day_clock   <= hhmmss;
    rec_ch.heading_deg <= heading;
    rec_ch.distance    <= radius;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: ready changes only at falling edges. It drops at random about
  // eight times in a hundred, never during the steady stretch, and once stays low
  // for a long hold-off so that the output register and then the input stall.
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin : stimulus
    logic [15:0]        id;
    logic [17:0]        hhmmss;
    logic signed [16:0] heading;
    logic [23:0]        radius;
    int unsigned        day_secs;
    int unsigned        pick;

    rst_n              = 1'b0;
    steady             = 1'b0;
    hold_start         = 1'b0;
    rec_ch.valid       = 1'b0;
    rec_ch.track_id    = '0;
    rec_ch.day_clock   = '0;
    rec_ch.heading_deg = '0;
    rec_ch.distance    = '0;
    day_secs           = 0;
    id                 = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed records. Track zero right after reset matches the cleared
    // track memory and counts from midnight.
    offer_record(16'h0000, 18'd0, 17'sd0, 24'd0);
    offer_record(16'h0000, 18'd1, 17'sd11520, 24'd256);
    offer_record(16'h0000, 18'd235959, -17'sd11520, 24'hFFFFFF);
    // Back to midnight: the end time is earlier, so the day wraps.
    offer_record(16'h0000, 18'd0, 17'sd23040, 24'hFFFFFF);
    // Malformed times: hour, minute and second out of range, then all ones.
    // None of them may touch the remembered track or time.
    offer_record(16'h0000, 18'd240000, 17'sd34560, 24'hFFFFFF);
    offer_record(16'h0000, 18'd6000, 17'sd46080, 24'd1000);
    offer_record(16'h0000, 18'd60, -17'sd46080, 24'd1000);
    offer_record(16'h0000, 18'h3FFFF, 17'sd65535, 24'hFFFFFF);
    // Elapsed time is still measured from midnight; heading is the most
    // negative value, well beyond a full turn.
    offer_record(16'h0000, 18'd10, -17'sd65536, 24'hFFFFFF);
    offer_record(16'hFFFF, 18'd120030, 17'sd5760, 24'hFFFFFF);
    // Same hour, earlier seconds: this must also wrap over midnight.
    offer_record(16'hFFFF, 18'd120010, -17'sd5760, 24'd12345);
    offer_record(16'hFFFF, 18'd120010, 17'sd1, 24'd1);
    offer_record(16'h8000, 18'd235959, 17'sd11519, 24'h800000);
    offer_record(16'h8000, 18'd0, 17'sd11521, 24'h7FFFFF);
    offer_record(16'h0001, 18'd123456, -17'sd1, 24'd1);
    offer_record(16'h0001, 18'd95959, 17'sd40000, 24'hAAAAAA);
    offer_record(16'h5555, 18'd235900, -17'sd23040, 24'h555555);
    offer_record(16'hAAAA, 18'd99, 17'sd128, 24'hFFFFFF);
    offer_record(16'hAAAA, 18'd100000, -17'sd34560, 24'hFFFFFF);
    // Malformed time on a matching track still reports the match.
    offer_record(16'hAAAA, 18'd109960, 17'sd34559, 24'hFFFFFF);
    offer_record(16'hAAAA, 18'd100500, -17'sd34561, 24'd65535);

    // Random records. About half of them keep the current track and most
    // times come a little after (or sometimes a little before) the last one,
    // so elapsed times and midnight wraps come up often; the rest are new
    // tracks, arbitrary times and raw bit patterns.
    for (int n = 0; n < 750; n++) begin
      steady = (n >= 200 && n < 330);
      if (n == 420) begin
        hold_start = 1'b1;
      end
      if (n == 560) begin
        // Let the block drain completely before going on.
        rec_ch.valid <= 1'b0;
        wait (open_fixes == 0);
        @(negedge clk);
      end

      pick = $urandom_range(99);
      if (pick >= 45 && pick < 85) begin
        case ($urandom_range(3))
          0: id = 16'h0000;
          1: id = 16'h0001;
          2: id = 16'hFFFF;
          default: id = 16'h1234;
        endcase
      end else if (pick >= 85) begin
        id = 16'($urandom());
      end

      pick = $urandom_range(99);
      if (pick < 12) begin
        hhmmss = 18'($urandom_range(18'h3FFFF));
      end else begin
        if (pick < 70) begin
          day_secs = (day_secs + $urandom_range(900)) % 86400;
        end else if (pick < 80) begin
          day_secs = (day_secs + 86400 - $urandom_range(900)) % 86400;
        end else begin
          day_secs = $urandom_range(86399);
        end
        hhmmss = 18'((day_secs / 3600) * 10000 + ((day_secs % 3600) / 60) * 100 +
                     day_secs % 60);
      end

      if ($urandom_range(99) < 10) begin
        heading = 17'($urandom_range(17'h1FFFF));
      end else begin
        heading = 17'(int'($urandom_range(92160)) - 46080);
      end

      pick = $urandom_range(99);
      if (pick < 25) begin
        radius = 24'($urandom_range(4095));
      end else if (pick < 35) begin
        radius = 24'hFFFFFF - 24'($urandom_range(255));
      end else begin
        radius = 24'($urandom());
      end

      offer_record(id, hhmmss, heading, radius);
    end
    rec_ch.valid <= 1'b0;
    steady = 1'b0;

    // Every result must come back; then a further wait catches any extra result.
    wait (open_fixes == 0);
    repeat (STAGES + 10) @(posedge clk);
    if (mismatches == 0 && open_fixes == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### track_record_processor_unit.f
rtl/core/trp_pkg.sv
rtl/core/trp_if.sv
rtl/core/trp_ctrl.sv
rtl/core/trp_dp.sv
rtl/core/track_record_processor_unit.sv
tb/sv/track_record_checker.sv
tb/sv/track_record_processor_unit_tb.sv
